// ----- hdl/seconds_to_calendar_date_defines.svh -----
// ----------------------------------------------------------------------------
// seconds_to_calendar_date assertion macros
// Shared assertion forms for the calendar conversion block.
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// same-cycle implication, held off during reset
`define STCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define STCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/stcd_pkg.sv -----
// ----------------------------------------------------------------------------
// stcd_pkg
// Types, constants and tables shared by the calendar conversion modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stcd_pkg;

  // time and calendar constants
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned DAYS_LEAP     = 366;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned MONTHS        = 12;
  localparam int unsigned CENTURY       = 100;
  // 2000-01-01 was a Saturday
  localparam int unsigned EPOCH_WEEKDAY = 6;

  // seconds per day is 675 << 7, so the day split divides the shifted count
  localparam int unsigned DAY_PRESHIFT  = 7;

  // reciprocal scaling: the estimate is exact or one low while x < 2**shift
  localparam int unsigned SHIFT_DAY  = 25;
  localparam int unsigned SHIFT_HOUR = 17;
  localparam int unsigned SHIFT_MIN  = 12;
  localparam int unsigned SHIFT_YEAR = 16;
  localparam int unsigned SHIFT_WEEK = 16;

  localparam int unsigned RECIP_DAY  =
    (2 ** SHIFT_DAY) / (SECS_PER_DAY / (2 ** DAY_PRESHIFT));
  localparam int unsigned RECIP_HOUR = (2 ** SHIFT_HOUR) / SECS_PER_HOUR;
  localparam int unsigned RECIP_MIN  = (2 ** SHIFT_MIN) / SECS_PER_MIN;
  localparam int unsigned RECIP_YEAR = (2 ** SHIFT_YEAR) / DAYS_COMMON;
  localparam int unsigned RECIP_WEEK = (2 ** SHIFT_WEEK) / DAYS_PER_WEEK;

  // constant divisions run on the shared multiplier, in this order
  typedef enum logic [2:0] {
    OP_DAY,
    OP_HOUR,
    OP_MIN,
    OP_YEAR,
    OP_WEEK
  } div_op_t;

  typedef struct packed {
    logic [16:0] divisor;
    logic [15:0] recip;
    logic [4:0]  shift;
  } div_const_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    div_op_t op;
    logic    est;
    logic    mul;
    logic    fix;
    logic    leap;
    logic    back;
    logic    month;
  } cmd_t;

  // divisor, reciprocal and shift for each division
  function automatic div_const_t div_consts(input div_op_t op);
    div_const_t c;
    unique case (op)
      OP_DAY: begin
        c.divisor = 17'(SECS_PER_DAY);
        c.recip   = 16'(RECIP_DAY);
        c.shift   = 5'(SHIFT_DAY);
      end
      OP_HOUR: begin
        c.divisor = 17'(SECS_PER_HOUR);
        c.recip   = 16'(RECIP_HOUR);
        c.shift   = 5'(SHIFT_HOUR);
      end
      OP_MIN: begin
        c.divisor = 17'(SECS_PER_MIN);
        c.recip   = 16'(RECIP_MIN);
        c.shift   = 5'(SHIFT_MIN);
      end
      OP_YEAR: begin
        c.divisor = 17'(DAYS_COMMON);
        c.recip   = 16'(RECIP_YEAR);
        c.shift   = 5'(SHIFT_YEAR);
      end
      OP_WEEK: begin
        c.divisor = 17'(DAYS_PER_WEEK);
        c.recip   = 16'(RECIP_WEEK);
        c.shift   = 5'(SHIFT_WEEK);
      end
      default: begin
        c.divisor = 17'(SECS_PER_DAY);
        c.recip   = 16'(RECIP_DAY);
        c.shift   = 5'(SHIFT_DAY);
      end
    endcase
    return c;
  endfunction

  // gregorian leap rule for 2000 + y, y below 256: only 2100 and 2200 drop out
  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != 8'(CENTURY)) && (y != 8'(2 * CENTURY));
  endfunction

  // zero based first day of each month
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic lp);
    logic [8:0] s;
    unique case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    // leap day pushes every month from March on
    if (lp && (m >= 4'd2) && (m < 4'(MONTHS))) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/stcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// stcd_ctrl
// Sequencer for the calendar conversion: steps the shared divider through
// its constant divisions and drives the leap, year and month steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seconds_to_calendar_date_defines.svh"

module stcd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output logic                done,
  output stcd_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EST,
    S_MUL,
    S_FIX,
    S_LEAP,
    S_BACK,
    S_MONTH
  } state_t;

  state_t            state;
  stcd_pkg::div_op_t op;

  // state, current division and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= stcd_pkg::OP_DAY;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EST;
            op    <= stcd_pkg::OP_DAY;
          end
        end
        S_EST:   state <= S_MUL;
        S_MUL:   state <= S_FIX;
        S_FIX: begin
          unique case (op)
            stcd_pkg::OP_DAY: begin
              op    <= stcd_pkg::OP_HOUR;
              state <= S_EST;
            end
            stcd_pkg::OP_HOUR: begin
              op    <= stcd_pkg::OP_MIN;
              state <= S_EST;
            end
            stcd_pkg::OP_MIN: begin
              op    <= stcd_pkg::OP_YEAR;
              state <= S_EST;
            end
            stcd_pkg::OP_YEAR: state <= S_LEAP;
            stcd_pkg::OP_WEEK: begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_LEAP:  state <= S_BACK;
        S_BACK:  state <= S_MONTH;
        S_MONTH: begin
          op    <= stcd_pkg::OP_WEEK;
          state <= S_EST;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    busy      = (state != S_IDLE);
    cmd.load  = (state == S_IDLE) && start;
    cmd.op    = op;
    cmd.est   = (state == S_EST);
    cmd.mul   = (state == S_MUL);
    cmd.fix   = (state == S_FIX);
    cmd.leap  = (state == S_LEAP);
    cmd.back  = (state == S_BACK);
    cmd.month = (state == S_MONTH);
  end

  // checks
  `STCD_ASSERT_NXT(a_accept_starts_day, clk, rst, start && !busy, (state == S_EST) && (op == stcd_pkg::OP_DAY), "accepted item did not start the day split")
  `STCD_ASSERT_NXT(a_done_after_week, clk, rst, (state == S_FIX) && (op == stcd_pkg::OP_WEEK), done && !busy, "weekday step did not end in a result")
  `STCD_ASSERT_IMP(a_done_single, clk, rst, done, !$past(done), "result strobe held for two cycles")

endmodule

`default_nettype wire

// ----- hdl/stcd_dpath.sv -----
// ----------------------------------------------------------------------------
// stcd_dpath
// Datapath for the calendar conversion: one reciprocal multiplier shared by
// all constant divisions, plus leap correction and month lookup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seconds_to_calendar_date_defines.svh"

module stcd_dpath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire stcd_pkg::cmd_t cmd,
  input  wire logic [31:0]    epoch_seconds,
  output logic [5:0]          second,
  output logic [5:0]          minute,
  output logic [4:0]          hour,
  output logic [7:0]          years_since_2000,
  output logic [8:0]          day_of_year,
  output logic [3:0]          month_index,
  output logic [4:0]          day_of_month,
  output logic [2:0]          weekday
);

  // item and intermediate registers
  logic [31:0]       t;
  logic [15:0]       days;
  logic [16:0]       sod;
  logic [11:0]       rest;
  logic [8:0]        ydrem;
  logic signed [9:0] yday_s;
  logic [15:0]       q;
  logic [31:0]       prod;

  // divider signals
  stcd_pkg::div_const_t dc;
  logic [31:0] num;
  logic [24:0] x;
  logic [40:0] est_prod;
  logic [15:0] est_q;
  logic [32:0] mul_full;
  logic [17:0] rem0;
  logic [17:0] rem1;
  logic        ge;
  logic [15:0] fix_q;
  logic [17:0] fix_r;

  // calendar signals
  logic [7:0]        ym1;
  logic [6:0]        leapdays;
  logic signed [9:0] yday_lin;
  logic [7:0]        yprev;
  logic signed [9:0] back_len;
  logic signed [9:0] yday_adj;
  logic              take_back;
  logic signed [9:0] back_val;
  logic              lp;
  logic [3:0]        mon_sel;
  logic [4:0]        mday_val;

  // shared constant divider: estimate, back-multiply, one correction
  always_comb begin
    dc = stcd_pkg::div_consts(cmd.op);
    unique case (cmd.op)
      stcd_pkg::OP_DAY:  num = t;
      stcd_pkg::OP_HOUR: num = {15'b0, sod};
      stcd_pkg::OP_MIN:  num = {20'b0, rest};
      stcd_pkg::OP_YEAR: num = {16'b0, days};
      stcd_pkg::OP_WEEK: num = {16'b0, days} + 32'(stcd_pkg::EPOCH_WEEKDAY);
      default:           num = t;
    endcase
    x        = (cmd.op == stcd_pkg::OP_DAY) ? 25'(t >> stcd_pkg::DAY_PRESHIFT)
                                            : 25'(num);
    est_prod = {16'b0, x} * {25'b0, dc.recip};
    est_q    = 16'(est_prod >> dc.shift);
    mul_full = {17'b0, q} * {16'b0, dc.divisor};
    rem0     = 18'(num - prod);
    rem1     = rem0 - {1'b0, dc.divisor};
    ge       = (rem0 >= {1'b0, dc.divisor});
    fix_q    = ge ? (q + 16'd1) : q;
    fix_r    = ge ? rem1 : rem0;
  end

  // leap day correction and step back a year
  always_comb begin
    ym1       = years_since_2000 - 8'd1;
    // every 400th year term is zero below year 2400
    leapdays  = (years_since_2000 == 8'd0) ? 7'd0 :
                7'(ym1 >> 2) - 7'(ym1 >= 8'(stcd_pkg::CENTURY))
                - 7'(ym1 >= 8'(2 * stcd_pkg::CENTURY)) + 7'd1;
    yday_lin  = $signed({1'b0, ydrem}) - $signed({3'b0, leapdays});
    yprev     = years_since_2000 - 8'd1;
    back_len  = stcd_pkg::is_leap(yprev) ? 10'sd366 : 10'sd365;
    yday_adj  = yday_s + back_len;
    take_back = (yday_s < 10'sd0) && (years_since_2000 != 8'd0);
    back_val  = take_back ? yday_adj : yday_s;
    if (back_val < 10'sd0) begin
      back_val = 10'sd0;
    end
  end

  // month lookup against first days of months
  always_comb begin
    lp      = stcd_pkg::is_leap(years_since_2000);
    mon_sel = 4'd0;
    for (int m = 1; m < stcd_pkg::MONTHS; m++) begin
      if (day_of_year >= stcd_pkg::month_start(4'(m), lp)) begin
        mon_sel = 4'(m);
      end
    end
    mday_val = 5'(day_of_year - stcd_pkg::month_start(mon_sel, lp) + 9'd1);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t <= epoch_seconds;
    end
    if (cmd.est) begin
      q <= est_q;
    end
    if (cmd.mul) begin
      prod <= mul_full[31:0];
    end
    if (cmd.fix) begin
      unique case (cmd.op)
        stcd_pkg::OP_DAY: begin
          days <= fix_q;
          sod  <= fix_r[16:0];
        end
        stcd_pkg::OP_HOUR: begin
          hour <= fix_q[4:0];
          rest <= fix_r[11:0];
        end
        stcd_pkg::OP_MIN: begin
          minute <= fix_q[5:0];
          second <= fix_r[5:0];
        end
        stcd_pkg::OP_YEAR: begin
          years_since_2000 <= fix_q[7:0];
          ydrem            <= fix_r[8:0];
        end
        stcd_pkg::OP_WEEK: weekday <= fix_r[2:0];
        default: ;
      endcase
    end
    if (cmd.leap) begin
      yday_s <= yday_lin;
    end
    if (cmd.back) begin
      if (take_back) begin
        years_since_2000 <= yprev;
      end
      day_of_year <= 9'(back_val);
    end
    if (cmd.month) begin
      month_index  <= mon_sel;
      day_of_month <= mday_val;
    end
  end

  // checks
  `STCD_ASSERT_IMP(a_hms_range, clk, rst, $past(cmd.fix) && ($past(cmd.op) == stcd_pkg::OP_MIN), (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24), "time of day out of range")
  `STCD_ASSERT_IMP(a_yday_range, clk, rst, $past(cmd.back), day_of_year <= 9'd365, "day of year out of range")
  `STCD_ASSERT_IMP(a_month_range, clk, rst, $past(cmd.month), (month_index < 4'd12) && (day_of_month != 5'd0), "month or day of month out of range")

endmodule

`default_nettype wire

// ----- hdl/seconds_to_calendar_date.sv -----
// Busy is high while an item is worked on; a new item is taken only when idle.
// Each item runs through the shared reciprocal divider: five constant
// divisions, each in an estimate, back-multiply and correction state, plus
// leap, year-back and month steps between the year and weekday divisions.
// Results are shown for one cycle under done; the receiver cannot stall.
// Reset (synchronous) returns the sequencer to idle with no strobe pending.
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts seconds since 2000-01-01 00:00:00 into time of day, year, day of
// year, month, day of month and weekday.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_date (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] epoch_seconds,
  output logic             done,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [7:0]       years_since_2000,
  output logic [8:0]       day_of_year,
  output logic [3:0]       month_index,
  output logic [4:0]       day_of_month,
  output logic [2:0]       weekday
);

  stcd_pkg::cmd_t cmd;

  // sequencer
  stcd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // arithmetic and result registers
  stcd_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .epoch_seconds    (epoch_seconds),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .years_since_2000 (years_since_2000),
    .day_of_year      (day_of_year),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .weekday          (weekday)
  );

endmodule

`default_nettype wire

// ----- bench/calendar_date_checker.sv -----
// ----------------------------------------------------------------------------
// calendar_date_checker
// Watches the command and result sides of the calendar conversion block,
// predicts the date and time for every accepted item and compares each
// strobed result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module calendar_date_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] epoch_seconds,
  input  wire logic        done,
  input  wire logic [5:0]  second,
  input  wire logic [5:0]  minute,
  input  wire logic [4:0]  hour,
  input  wire logic [7:0]  years_since_2000,
  input  wire logic [8:0]  day_of_year,
  input  wire logic [3:0]  month_index,
  input  wire logic [4:0]  day_of_month,
  input  wire logic [2:0]  weekday,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BASE_YEAR = 2000;

  typedef struct {
    logic [5:0] sec;
    logic [5:0] mins;
    logic [4:0] hr;
    logic [7:0] yr;
    logic [8:0] yday;
    logic [3:0] mon;
    logic [4:0] mday;
    logic [2:0] wday;
  } date_fields_t;

  date_fields_t expected_dates[$];
  int           errors = 0;

  // gregorian rule on the offset from the base year
  function automatic bit leap_year(input int unsigned yoff);
    int unsigned y;
    y = BASE_YEAR + yoff;
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned mon, input bit lp);
    case (mon)
      1:       return lp ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  // per-month offset for the weekday sum
  function automatic int unsigned weekday_offset(input int unsigned mon);
    case (mon)
      0, 4:    return 0;
      1, 5:    return 3;
      2, 10:   return 2;
      3:       return 5;
      6:       return 5;
      7:       return 1;
      8, 11:   return 4;
      default: return 6;
    endcase
  endfunction

  // full conversion of one item
  function automatic date_fields_t predict_date(input logic [31:0] t);
    date_fields_t r;
    int unsigned  secs, sod, days, hr, rest, mins, yr, mday, mon, fy, wd;
    int           leapdays, yday;
    bit           lp;
    secs = t;
    sod  = secs % stcd_pkg::SECS_PER_DAY;
    days = secs / stcd_pkg::SECS_PER_DAY;
    hr   = sod / stcd_pkg::SECS_PER_HOUR;
    rest = sod - hr * stcd_pkg::SECS_PER_HOUR;
    mins = rest / 60;

    // common years first, then take off the leap days so far
    yr = days / stcd_pkg::DAYS_COMMON;
    leapdays = 0;
    if (yr > 0) begin
      leapdays = int'((yr - 1) / 4) - int'((yr - 1) / 100) + int'((yr - 1) / 400) + 1;
    end
    yday = int'(days % stcd_pkg::DAYS_COMMON) - leapdays;
    if (yday < 0 && yr > 0) begin
      yr   = yr - 1;
      yday = yday + (leap_year(yr) ? int'(stcd_pkg::DAYS_LEAP) : int'(stcd_pkg::DAYS_COMMON));
    end
    if (yday < 0) begin
      yday = 0;
    end

    // month walk, never past december
    lp   = leap_year(yr);
    mday = int'(yday) + 1;
    mon  = 0;
    while (mon < 11 && mday > month_days(mon, lp)) begin
      mday = mday - month_days(mon, lp);
      mon  = mon + 1;
    end

    // january and february count in the previous year
    fy = BASE_YEAR + yr - ((mon < 2) ? 1 : 0);
    wd = (fy + fy / 4 - fy / 100 + fy / 400 + weekday_offset(mon) + mday) % 7;

    r.sec  = 6'(rest - mins * 60);
    r.mins = 6'(mins);
    r.hr   = 5'(hr);
    r.yr   = 8'(yr);
    r.yday = 9'(yday);
    r.mon  = 4'(mon);
    r.mday = 5'(mday);
    r.wday = 3'(wd);
    return r;
  endfunction

  task automatic check_field(input string label, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      errors++;
    end
  endtask

  // results first, so a stray strobe never takes a fresh prediction
  always @(posedge clk) begin : watch
    date_fields_t want;
    if (!rst) begin
      if (done) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got second %0d",
                   $time, second);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          check_field("second", want.sec, second);
          check_field("minute", want.mins, minute);
          check_field("hour", want.hr, hour);
          check_field("years_since_2000", want.yr, years_since_2000);
          check_field("day_of_year", want.yday, day_of_year);
          check_field("month_index", want.mon, month_index);
          check_field("day_of_month", want.mday, day_of_month);
          check_field("weekday", want.wday, weekday);
        end
      end
      if (start && !busy) begin
        expected_dates.push_back(predict_date(epoch_seconds));
      end
    end
    fail_count  <= errors;
    outstanding <= expected_dates.size();
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the calendar conversion block with directed dates around year,
// month and leap boundaries, then random second counts, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 25;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] epoch_seconds;
  logic        done;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [7:0]  years_since_2000;
  logic [8:0]  day_of_year;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;

  always #5 clk = ~clk;

  seconds_to_calendar_date dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .done             (done),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .years_since_2000 (years_since_2000),
    .day_of_year      (day_of_year),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .weekday          (weekday)
  );

  calendar_date_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .done             (done),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .years_since_2000 (years_since_2000),
    .day_of_year      (day_of_year),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .weekday          (weekday),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  // days from the epoch to january 1st of the given year offset
  function automatic int unsigned days_before_year(input int unsigned y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint unsigned date_secs(input int unsigned y, input int unsigned doy,
                                                input int unsigned sod);
    return longint'(days_before_year(y) + doy) * 86400 + sod;
  endfunction

  // mostly real dates near year and leap-day edges, the rest raw counts
  function automatic logic [31:0] pick_seconds();
    int unsigned       y, ylen, doy, sod;
    longint unsigned   total;
    if ($urandom_range(0, 99) < 35) begin
      return $urandom;
    end
    y    = $urandom_range(0, 136);
    ylen = days_before_year(y + 1) - days_before_year(y);
    case ($urandom_range(0, 4))
      0:       doy = 0;
      1:       doy = ylen - 1;
      2:       doy = $urandom_range(57, 60);
      default: doy = $urandom_range(0, ylen - 1);
    endcase
    case ($urandom_range(0, 3))
      0:       sod = 0;
      1:       sod = 86399;
      default: sod = $urandom_range(0, 86399);
    endcase
    total = date_secs(y, doy, sod);
    if (total > 64'hFFFF_FFFF) begin
      return $urandom;
    end
    return total[31:0];
  endfunction

  // one item, with an occasional idle spell before it
  task automatic send_item(input logic [31:0] secs, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 40) begin
      gap = $urandom_range(1, 12);
      start         <= 1'b0;
      epoch_seconds <= $urandom;
      // wait for the block to free up, so the gap shows on the handshake
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[seconds_to_calendar_date] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    rst           <= 1'b1;
    start         <= 1'b0;
    epoch_seconds <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed dates: extremes, leap days, year ends, the skipped 2100 leap day
    send_item(32'd0, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'd86399, 1'b1);
    send_item(32'(date_secs(0, 45, 3600)), 1'b1);
    send_item(32'(date_secs(0, 58, 43200)), 1'b1);
    send_item(32'(date_secs(0, 59, 0)), 1'b1);
    send_item(32'(date_secs(0, 60, 0)), 1'b1);
    send_item(32'(date_secs(0, 335, 0)), 1'b1);
    send_item(32'(date_secs(0, 365, 86399)), 1'b1);
    send_item(32'(date_secs(1, 0, 0)), 1'b1);
    send_item(32'(date_secs(1, 30, 86399)), 1'b1);
    send_item(32'(date_secs(1, 31, 0)), 1'b1);
    send_item(32'(date_secs(3, 364, 86399)), 1'b1);
    send_item(32'(date_secs(4, 0, 0)), 1'b1);
    send_item(32'(date_secs(99, 364, 86399)), 1'b1);
    send_item(32'(date_secs(100, 58, 0)), 1'b1);
    send_item(32'(date_secs(100, 59, 0)), 1'b1);
    send_item(32'(date_secs(100, 364, 86399)), 1'b1);
    send_item(32'(date_secs(101, 0, 0)), 1'b1);
    send_item(32'(date_secs(104, 59, 0)), 1'b1);
    send_item(32'(date_secs(135, 364, 86399)), 1'b1);
    send_item(32'(date_secs(136, 0, 0)), 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b1);

    // random items, with a stretch held back to back
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(pick_seconds(), !(n >= 400 && n < 650));
    end
    start <= 1'b0;

    // drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[seconds_to_calendar_date] OK");
    end else begin
      $display("[seconds_to_calendar_date] ERROR");
    end
    $finish;
  end

endmodule
